[rtl/core/pdcs_pkg.sv]
// ----------------------------------------------------------------------------
// pdcs_pkg
// Shared widths, register indexes, input type codes and pipeline control
// types for the pot dead-band command scaler.
// ----------------------------------------------------------------------------
package pdcs_pkg;

    // Default number of live bits in a raw sample
    localparam int SAMPLE_WIDTH = 16;

    // Field widths
    localparam int RAW_W      = 16;   // raw sample as carried on the bus
    localparam int CMD_W      = 16;   // command word
    localparam int CFG_IDX_W  = 3;    // register index
    localparam int CFG_DATA_W = 16;   // widest register
    localparam int TYPE_W     = 2;
    localparam int BAND_W     = 15;   // dead band and out_max

    // Datapath widths
    localparam int EDGE_W  = 18;      // cal_mid +/- dead_band
    localparam int DIFF_W  = 18;      // x - a and b - a
    localparam int SCALE_W = 16;      // d - c, between -32768 and 32767
    localparam int PROD_W  = DIFF_W + SCALE_W;
    localparam int MAG_W   = PROD_W - 1;  // product magnitude
    localparam int DEN_W   = DIFF_W;      // divisor magnitude

    // Input type codes
    localparam logic [TYPE_W-1:0] TYPE_DISABLED = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_NORMAL   = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_CENTRE   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd6;

    // Configuration register set
    typedef struct packed {
        logic [TYPE_W-1:0]        input_type;
        logic signed [RAW_W-1:0]  cal_min;
        logic signed [RAW_W-1:0]  cal_mid;
        logic signed [RAW_W-1:0]  cal_max;
        logic [BAND_W-1:0]        dead_band;
        logic signed [CMD_W-1:0]  out_min;
        logic [BAND_W-1:0]        out_max;
    } cfg_t;

    // Per-word control that travels down the pipeline
    typedef struct packed {
        logic                     zero;   // command is 0 with no fault
        logic                     fault;  // span was zero
        logic                     neg;    // quotient is negative
        logic signed [CMD_W-1:0]  lo;     // lower clamp bound
        logic signed [CMD_W-1:0]  hi;     // upper clamp bound
    } ctrl_t;

endpackage

[rtl/core/pdcs_operand.sv]
// ----------------------------------------------------------------------------
// pdcs_operand
// Two stages: sign-extend the sample and form the band edges, then pick the
// mapping segment and form x - a, b - a and the output span.
// ----------------------------------------------------------------------------
module pdcs_operand #(
    parameter int SAMPLE_WIDTH = pdcs_pkg::SAMPLE_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [pdcs_pkg::RAW_W-1:0]           in_sample,
    input  pdcs_pkg::cfg_t                       cfg,
    output logic                                 out_valid,
    output logic signed [pdcs_pkg::DIFF_W-1:0]   out_xa,
    output logic signed [pdcs_pkg::DIFF_W-1:0]   out_den,
    output logic signed [pdcs_pkg::SCALE_W-1:0]  out_scale,
    output pdcs_pkg::ctrl_t                      out_ctrl
);

    localparam int RAW_W     = pdcs_pkg::RAW_W;
    localparam int EDGE_W    = pdcs_pkg::EDGE_W;
    localparam int DIFF_W    = pdcs_pkg::DIFF_W;
    localparam int SCALE_W   = pdcs_pkg::SCALE_W;
    localparam int BAND_W    = pdcs_pkg::BAND_W;
    localparam int EXT_SHIFT = RAW_W - SAMPLE_WIDTH;

    // Stage 1 registers
    logic                       s1_valid_reg;
    logic signed [RAW_W-1:0]    s1_raw_reg;
    logic signed [EDGE_W-1:0]   s1_edge_lo_reg, s1_edge_hi_reg;
    logic [1:0]                 s1_type_reg;
    logic signed [RAW_W-1:0]    s1_cal_min_reg, s1_cal_max_reg, s1_cal_mid_reg;
    logic signed [SCALE_W-1:0]  s1_out_max_reg, s1_lo_lim_reg;

    logic signed [RAW_W-1:0]    raw_shl, raw_ext;
    logic signed [EDGE_W-1:0]   mid_ext, band_ext;
    logic signed [EDGE_W-1:0]   edge_lo_next, edge_hi_next;
    logic signed [SCALE_W-1:0]  out_max_next, lo_lim_next;

    // Sign-extend the live sample bits
    assign raw_shl = $signed(in_sample << EXT_SHIFT);
    assign raw_ext = raw_shl >>> EXT_SHIFT;

    // Band edges around the centre
    assign mid_ext      = $signed({{(EDGE_W-RAW_W){cfg.cal_mid[RAW_W-1]}}, cfg.cal_mid});
    assign band_ext     = $signed({{(EDGE_W-BAND_W){1'b0}}, cfg.dead_band});
    assign edge_lo_next = mid_ext - band_ext;
    assign edge_hi_next = mid_ext + band_ext;

    // Lower output limit, never above zero
    assign out_max_next = $signed({{(SCALE_W-BAND_W){1'b0}}, cfg.out_max});
    assign lo_lim_next  = (!cfg.out_min[SCALE_W-1] && (cfg.out_min != '0)) ? '0
                                                                          : cfg.out_min;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_raw_reg     <= raw_ext;
            s1_edge_lo_reg <= edge_lo_next;
            s1_edge_hi_reg <= edge_hi_next;
            s1_type_reg    <= cfg.input_type;
            s1_cal_min_reg <= cfg.cal_min;
            s1_cal_max_reg <= cfg.cal_max;
            s1_cal_mid_reg <= cfg.cal_mid;
            s1_out_max_reg <= out_max_next;
            s1_lo_lim_reg  <= lo_lim_next;
        end
    end

    // Stage 2: segment select
    logic signed [EDGE_W-1:0]   raw_wide, min_wide, max_wide;
    logic signed [EDGE_W-1:0]   a_sel, b_sel;
    logic signed [SCALE_W-1:0]  d_sel;
    logic                       in_band, upper;
    pdcs_pkg::ctrl_t            ctrl_next;
    logic signed [DIFF_W-1:0]   xa_next, den_next;

    assign raw_wide = $signed({{(EDGE_W-RAW_W){s1_raw_reg[RAW_W-1]}}, s1_raw_reg});
    assign min_wide = $signed({{(EDGE_W-RAW_W){s1_cal_min_reg[RAW_W-1]}}, s1_cal_min_reg});
    assign max_wide = $signed({{(EDGE_W-RAW_W){s1_cal_max_reg[RAW_W-1]}}, s1_cal_max_reg});
    assign in_band  = (raw_wide > s1_edge_lo_reg) && (raw_wide < s1_edge_hi_reg);
    assign upper    = s1_raw_reg > s1_cal_mid_reg;

    always_comb begin
        a_sel           = '0;
        b_sel           = '0;
        d_sel           = '0;
        ctrl_next.zero  = 1'b1;
        ctrl_next.fault = 1'b0;
        ctrl_next.neg   = 1'b0;
        ctrl_next.lo    = '0;
        ctrl_next.hi    = '0;
        case (s1_type_reg)
            pdcs_pkg::TYPE_NORMAL: begin
                a_sel          = min_wide;
                b_sel          = max_wide;
                d_sel          = s1_out_max_reg;
                ctrl_next.zero = 1'b0;
                ctrl_next.hi   = s1_out_max_reg;
            end
            pdcs_pkg::TYPE_CENTRE: begin
                if (in_band) begin
                    ctrl_next.zero = 1'b1;
                end else if (upper) begin
                    a_sel          = s1_edge_hi_reg;
                    b_sel          = max_wide;
                    d_sel          = s1_out_max_reg;
                    ctrl_next.zero = 1'b0;
                    ctrl_next.hi   = s1_out_max_reg;
                end else begin
                    a_sel          = s1_edge_lo_reg;
                    b_sel          = min_wide;
                    d_sel          = s1_lo_lim_reg;
                    ctrl_next.zero = 1'b0;
                    ctrl_next.lo   = s1_lo_lim_reg;
                end
            end
            default: begin
                ctrl_next.zero = 1'b1;
            end
        endcase
    end

    assign xa_next  = raw_wide - a_sel;
    assign den_next = b_sel - a_sel;

    // Stage 2 registers
    logic                       s2_valid_reg;
    logic signed [DIFF_W-1:0]   s2_xa_reg, s2_den_reg;
    logic signed [SCALE_W-1:0]  s2_scale_reg;
    pdcs_pkg::ctrl_t            s2_ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_xa_reg    <= xa_next;
            s2_den_reg   <= den_next;
            s2_scale_reg <= d_sel;
            s2_ctrl_reg  <= ctrl_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_xa    = s2_xa_reg;
    assign out_den   = s2_den_reg;
    assign out_scale = s2_scale_reg;
    assign out_ctrl  = s2_ctrl_reg;

endmodule

[rtl/core/pdcs_mul.sv]
// ----------------------------------------------------------------------------
// pdcs_mul
// Two stages: multiply (x - a) by the output span and take the divisor
// magnitude, then take the product magnitude and the quotient sign.
// ----------------------------------------------------------------------------
module pdcs_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [pdcs_pkg::DIFF_W-1:0]   in_xa,
    input  logic signed [pdcs_pkg::DIFF_W-1:0]   in_den,
    input  logic signed [pdcs_pkg::SCALE_W-1:0]  in_scale,
    input  pdcs_pkg::ctrl_t                      in_ctrl,
    output logic                                 out_valid,
    output logic [pdcs_pkg::MAG_W-1:0]           out_dividend,
    output logic [pdcs_pkg::DEN_W-1:0]           out_divisor,
    output pdcs_pkg::ctrl_t                      out_ctrl
);

    localparam int DIFF_W = pdcs_pkg::DIFF_W;
    localparam int PROD_W = pdcs_pkg::PROD_W;
    localparam int MAG_W  = pdcs_pkg::MAG_W;
    localparam int DEN_W  = pdcs_pkg::DEN_W;

    // Stage 3: product and divisor magnitude
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [DIFF_W-1:0]  den_neg_val;
    logic [DEN_W-1:0]          den_mag_next;
    pdcs_pkg::ctrl_t           ctrl3_next;

    assign prod_next    = in_xa * in_scale;
    assign den_neg_val  = -in_den;
    assign den_mag_next = in_den[DIFF_W-1] ? den_neg_val : in_den;

    // Flag a zero span only where a map is really done
    always_comb begin
        ctrl3_next       = in_ctrl;
        ctrl3_next.fault = !in_ctrl.zero && (in_den == '0);
    end

    logic                      s3_valid_reg;
    logic signed [PROD_W-1:0]  s3_prod_reg;
    logic                      s3_den_neg_reg;
    logic [DEN_W-1:0]          s3_den_mag_reg;
    pdcs_pkg::ctrl_t           s3_ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_prod_reg    <= prod_next;
            s3_den_neg_reg <= in_den[DIFF_W-1];
            s3_den_mag_reg <= den_mag_next;
            s3_ctrl_reg    <= ctrl3_next;
        end
    end

    // Stage 4: product magnitude and quotient sign
    logic signed [PROD_W-1:0]  prod_neg_val;
    logic [MAG_W-1:0]          prod_mag_next;
    pdcs_pkg::ctrl_t           ctrl4_next;

    assign prod_neg_val  = -s3_prod_reg;
    assign prod_mag_next = s3_prod_reg[PROD_W-1] ? prod_neg_val[MAG_W-1:0]
                                                 : s3_prod_reg[MAG_W-1:0];

    always_comb begin
        ctrl4_next     = s3_ctrl_reg;
        ctrl4_next.neg = s3_prod_reg[PROD_W-1] ^ s3_den_neg_reg;
    end

    logic                      s4_valid_reg;
    logic [MAG_W-1:0]          s4_prod_mag_reg;
    logic [DEN_W-1:0]          s4_den_mag_reg;
    pdcs_pkg::ctrl_t           s4_ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_prod_mag_reg <= prod_mag_next;
            s4_den_mag_reg  <= s3_den_mag_reg;
            s4_ctrl_reg     <= ctrl4_next;
        end
    end

    assign out_valid    = s4_valid_reg;
    assign out_dividend = s4_prod_mag_reg;
    assign out_divisor  = s4_den_mag_reg;
    assign out_ctrl     = s4_ctrl_reg;

endmodule

[rtl/core/pdcs_div.sv]
// ----------------------------------------------------------------------------
// pdcs_div
// Pipelined restoring divider on magnitudes: one quotient bit per stage,
// one stage per dividend bit. Dividend bits shift out of the top of the
// word while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module pdcs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [pdcs_pkg::MAG_W-1:0]  in_dividend,
    input  logic [pdcs_pkg::DEN_W-1:0]  in_divisor,
    input  pdcs_pkg::ctrl_t             in_ctrl,
    output logic                        out_valid,
    output logic [pdcs_pkg::MAG_W-1:0]  out_quotient,
    output pdcs_pkg::ctrl_t             out_ctrl
);

    localparam int MAG_W = pdcs_pkg::MAG_W;
    localparam int DEN_W = pdcs_pkg::DEN_W;

    logic                 vld_reg [MAG_W];
    logic [MAG_W-1:0]     quo_reg [MAG_W];
    logic [DEN_W-1:0]     rem_reg [MAG_W];
    logic [DEN_W-1:0]     dvs_reg [MAG_W];
    pdcs_pkg::ctrl_t      ctl_reg [MAG_W];

    for (genvar k = 0; k < MAG_W; k++) begin : g_stage
        logic              vld_in;
        logic [MAG_W-1:0]  quo_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  dvs_in;
        pdcs_pkg::ctrl_t   ctl_in;
        logic [DEN_W:0]    rem_sh;
        logic [DEN_W:0]    rem_diff;
        logic              fits;
        logic [MAG_W-1:0]  quo_next;
        logic [DEN_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign vld_in = in_valid;
            assign quo_in = in_dividend;
            assign rem_in = '0;
            assign dvs_in = in_divisor;
            assign ctl_in = in_ctrl;
        end else begin : g_next
            assign vld_in = vld_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign ctl_in = ctl_reg[k-1];
        end

        // Bring down the next dividend bit and try the subtract
        assign rem_sh   = {rem_in, quo_in[MAG_W-1]};
        assign rem_diff = rem_sh - {1'b0, dvs_in};
        assign fits     = rem_sh >= {1'b0, dvs_in};
        assign rem_next = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        assign quo_next = {quo_in[MAG_W-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= quo_next;
                rem_reg[k] <= rem_next;
                dvs_reg[k] <= dvs_in;
                ctl_reg[k] <= ctl_in;
            end
        end
    end

    assign out_valid    = vld_reg[MAG_W-1];
    assign out_quotient = quo_reg[MAG_W-1];
    assign out_ctrl     = ctl_reg[MAG_W-1];

endmodule

[rtl/core/pdcs_clamp.sv]
// ----------------------------------------------------------------------------
// pdcs_clamp
// Two stages: apply the quotient sign, then clamp to the segment bounds and
// force zero for the dead band, a disabled input or a zero span. The second
// stage is the output register.
// ----------------------------------------------------------------------------
module pdcs_clamp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [pdcs_pkg::MAG_W-1:0]         in_quotient,
    input  pdcs_pkg::ctrl_t                    in_ctrl,
    output logic                               out_valid,
    output logic signed [pdcs_pkg::CMD_W-1:0]  out_command,
    output logic                               out_fault
);

    localparam int MAG_W  = pdcs_pkg::MAG_W;
    localparam int PROD_W = pdcs_pkg::PROD_W;
    localparam int CMD_W  = pdcs_pkg::CMD_W;

    // Stage A: signed quotient
    logic signed [PROD_W-1:0]  q_pos, q_neg, q_next;

    assign q_pos  = $signed({1'b0, in_quotient});
    assign q_neg  = -q_pos;
    assign q_next = in_ctrl.neg ? q_neg : q_pos;

    logic                      sa_valid_reg;
    logic signed [PROD_W-1:0]  sa_q_reg;
    pdcs_pkg::ctrl_t           sa_ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
        end else if (en) begin
            sa_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_q_reg    <= q_next;
            sa_ctrl_reg <= in_ctrl;
        end
    end

    // Stage B: clamp and force zero
    logic signed [PROD_W-1:0]  lo_wide, hi_wide;
    logic signed [CMD_W-1:0]   cmd_next;

    assign lo_wide = $signed({{(PROD_W-CMD_W){sa_ctrl_reg.lo[CMD_W-1]}}, sa_ctrl_reg.lo});
    assign hi_wide = $signed({{(PROD_W-CMD_W){sa_ctrl_reg.hi[CMD_W-1]}}, sa_ctrl_reg.hi});

    always_comb begin
        if (sa_ctrl_reg.zero || sa_ctrl_reg.fault) begin
            cmd_next = '0;
        end else if (sa_q_reg < lo_wide) begin
            cmd_next = sa_ctrl_reg.lo;
        end else if (sa_q_reg > hi_wide) begin
            cmd_next = sa_ctrl_reg.hi;
        end else begin
            cmd_next = sa_q_reg[CMD_W-1:0];
        end
    end

    logic                      sb_valid_reg;
    logic signed [CMD_W-1:0]   sb_cmd_reg;
    logic                      sb_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_valid_reg <= 1'b0;
        end else if (en) begin
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_cmd_reg   <= cmd_next;
            sb_fault_reg <= sa_ctrl_reg.fault;
        end
    end

    assign out_valid   = sb_valid_reg;
    assign out_command = sb_cmd_reg;
    assign out_fault   = sb_fault_reg;

endmodule

[rtl/core/pot_deadband_command_scaler.sv]
// ----------------------------------------------------------------------------
// pot_deadband_command_scaler
// Pipeline from an accepted sample to its command word on m_*:
// 2 operand stages, 2 multiply stages, 33 divider stages, 2 clamp stages.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word waits on m_tready.
// Reset: aresetn low clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module pot_deadband_command_scaler #(
    parameter int SAMPLE_WIDTH = pdcs_pkg::SAMPLE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [pdcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdcs_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Sample input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pdcs_pkg::RAW_W-1:0]          s_tdata,   // [15:0] raw_sample

    // Command output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pdcs_pkg::CMD_W-1:0]          m_tdata,   // [15:0] command
    output logic                                m_tuser    // [0] divide_fault
);

    localparam int DIFF_W  = pdcs_pkg::DIFF_W;
    localparam int SCALE_W = pdcs_pkg::SCALE_W;
    localparam int MAG_W   = pdcs_pkg::MAG_W;
    localparam int DEN_W   = pdcs_pkg::DEN_W;
    localparam int CMD_W   = pdcs_pkg::CMD_W;
    localparam int BAND_W  = pdcs_pkg::BAND_W;
    localparam int TYPE_W  = pdcs_pkg::TYPE_W;

    // Configuration registers
    pdcs_pkg::cfg_t  cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_type <= pdcs_pkg::TYPE_DISABLED;
            cfg_reg.cal_min    <= 16'sd0;
            cfg_reg.cal_mid    <= 16'sd0;
            cfg_reg.cal_max    <= 16'sd4095;
            cfg_reg.dead_band  <= 15'd0;
            cfg_reg.out_min    <= -16'sd1000;
            cfg_reg.out_max    <= 15'd1000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pdcs_pkg::REG_INPUT_TYPE: cfg_reg.input_type <= cfg_data[TYPE_W-1:0];
                pdcs_pkg::REG_CAL_MIN:    cfg_reg.cal_min    <= $signed(cfg_data);
                pdcs_pkg::REG_CAL_MID:    cfg_reg.cal_mid    <= $signed(cfg_data);
                pdcs_pkg::REG_CAL_MAX:    cfg_reg.cal_max    <= $signed(cfg_data);
                pdcs_pkg::REG_DEAD_BAND:  cfg_reg.dead_band  <= cfg_data[BAND_W-1:0];
                pdcs_pkg::REG_OUT_MIN:    cfg_reg.out_min    <= $signed(cfg_data);
                pdcs_pkg::REG_OUT_MAX:    cfg_reg.out_max    <= cfg_data[BAND_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Advance the pipeline unless the output word is stalled
    logic  en;
    logic  out_valid;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    // Operand stages
    logic                         op_valid;
    logic signed [DIFF_W-1:0]     op_xa, op_den;
    logic signed [SCALE_W-1:0]    op_scale;
    pdcs_pkg::ctrl_t              op_ctrl;

    pdcs_operand #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_operand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_sample (s_tdata),
        .cfg       (cfg_reg),
        .out_valid (op_valid),
        .out_xa    (op_xa),
        .out_den   (op_den),
        .out_scale (op_scale),
        .out_ctrl  (op_ctrl)
    );

    // Multiply stages
    logic                  mul_valid;
    logic [MAG_W-1:0]      mul_dividend;
    logic [DEN_W-1:0]      mul_divisor;
    pdcs_pkg::ctrl_t       mul_ctrl;

    pdcs_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (op_valid),
        .in_xa        (op_xa),
        .in_den       (op_den),
        .in_scale     (op_scale),
        .in_ctrl      (op_ctrl),
        .out_valid    (mul_valid),
        .out_dividend (mul_dividend),
        .out_divisor  (mul_divisor),
        .out_ctrl     (mul_ctrl)
    );

    // Divider stages
    logic                  div_valid;
    logic [MAG_W-1:0]      div_quotient;
    pdcs_pkg::ctrl_t       div_ctrl;

    pdcs_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (mul_valid),
        .in_dividend  (mul_dividend),
        .in_divisor   (mul_divisor),
        .in_ctrl      (mul_ctrl),
        .out_valid    (div_valid),
        .out_quotient (div_quotient),
        .out_ctrl     (div_ctrl)
    );

    // Clamp and output register
    logic signed [CMD_W-1:0]  out_command;
    logic                     out_fault;

    pdcs_clamp u_clamp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (div_valid),
        .in_quotient (div_quotient),
        .in_ctrl     (div_ctrl),
        .out_valid   (out_valid),
        .out_command (out_command),
        .out_fault   (out_fault)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = out_command;
    assign m_tuser  = out_fault;

endmodule
